FILE: src/tip_pkg.sv
// shared types and constants for the text to integer parser
// no dependencies
`default_nettype none

package tip_pkg;

  localparam logic RegNumberBase = 1'b0;
  localparam logic RegSignedMode = 1'b1;

  localparam logic [5:0]  BaseMin   = 6'd2;
  localparam logic [5:0]  BaseMax   = 6'd36;
  localparam logic [5:0]  BaseOct   = 6'd8;
  localparam logic [5:0]  BaseDec   = 6'd10;
  localparam logic [5:0]  BaseHex   = 6'd16;
  localparam logic [5:0]  BaseAuto  = 6'd0;
  localparam logic [63:0] SignedMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SignedMin = 64'h8000_0000_0000_0000;

  typedef enum logic [5:0] {
    PhDone   = 6'b000001,
    PhSpace  = 6'b000010,
    PhSign   = 6'b000100,
    PhZero   = 6'b001000,
    PhZeroX  = 6'b010000,
    PhDigits = 6'b100000
  } tip_phase_e;

  // classified character as it travels from front to back
  typedef struct packed {
    logic       first;
    logic       space;
    logic       plus;
    logic       minus;
    logic       zero;
    logic       hex_x;
    logic       alnum;
    logic [5:0] val;
  } tip_item_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [12:0] end_offset;
    logic        converted;
    logic        too_long;
  } tip_result_t;

endpackage

`default_nettype wire

FILE: src/tip_fifo.sv
// small register queue between the front and the back
// no dependencies
`default_nettype none

module tip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/tip_front.sv
// input side: takes characters and classifies them for the parse engine
// depends on tip_pkg
`default_nettype none

module tip_front import tip_pkg::*; (
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       first_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output tip_item_t       q_item_o
);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o       = '0;
    q_item_o.first = first_i;
    q_item_o.space = (char_in_i == 8'h20) || (char_in_i inside {[8'd9:8'd13]});
    q_item_o.plus  = (char_in_i == 8'h2B);
    q_item_o.minus = (char_in_i == 8'h2D);
    q_item_o.zero  = (char_in_i == 8'h30);
    q_item_o.hex_x = (char_in_i == 8'h78) || (char_in_i == 8'h58);
    if (char_in_i inside {[8'h30:8'h39]}) begin
      q_item_o.alnum = 1'b1;
      q_item_o.val   = 6'(char_in_i - 8'h30);
    end else if (char_in_i inside {[8'h61:8'h7A]}) begin
      q_item_o.alnum = 1'b1;
      q_item_o.val   = 6'(char_in_i - 8'h57);
    end else if (char_in_i inside {[8'h41:8'h5A]}) begin
      q_item_o.alnum = 1'b1;
      q_item_o.val   = 6'(char_in_i - 8'h37);
    end
  end

endmodule

`default_nettype wire

FILE: src/tip_back.sv
// parse engine: phase machine, accumulator and result register
// depends on tip_pkg
`default_nettype none

module tip_back import tip_pkg::*; #(
  parameter int MAX_LEN = 4096
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [5:0] number_base_i,
  input  wire logic       signed_mode_i,
  input  wire logic       item_valid_i,
  input  wire tip_item_t  item_i,
  output logic            item_pop_o,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output tip_result_t     res_o
);

  localparam int PosW = $clog2(MAX_LEN + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LEN);

  tip_phase_e     phase_q, phase_d;
  logic [63:0]    acc_q, acc_d;
  logic [5:0]     base_q, base_d;
  logic           neg_q, neg_d;
  logic           seen_q, seen_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] zeo_q, zeo_d;
  logic           sat_q, sat_d;
  logic           out_valid_q, out_valid_d;
  tip_result_t    res_q, res_d;
  logic           pop;

  assign pop         = item_valid_i && (!out_valid_q || res_ready_i);
  assign item_pop_o  = pop;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic            consumed;
    logic            adv;
    logic            fin;
    logic            conv;
    logic            dok;
    logic [PosW-1:0] fin_end;
    logic [63:0]     v;
    logic [63:0]     r;
    logic [PosW+12:0] end_ext;
    consumed = 1'b0;
    adv      = 1'b0;
    fin      = 1'b0;
    conv     = 1'b0;
    dok      = 1'b0;
    fin_end  = '0;
    v        = '0;
    r        = '0;
    end_ext  = '0;
    phase_d  = phase_q;
    acc_d    = acc_q;
    base_d   = base_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    pos_d    = pos_q;
    zeo_d    = zeo_q;
    sat_d    = sat_q;
    out_valid_d = out_valid_q && !res_ready_i;
    res_d    = res_q;
    if (pop && item_i.first) begin
      phase_d = PhSpace;
      acc_d   = '0;
      base_d  = number_base_i;
      neg_d   = 1'b0;
      seen_d  = 1'b0;
      pos_d   = '0;
      zeo_d   = '0;
      sat_d   = 1'b0;
    end
    if (pop && phase_d != PhDone) begin
      if (phase_d == PhSpace) begin
        if (item_i.space) begin
          adv      = 1'b1;
          consumed = 1'b1;
        end else if (item_i.plus || item_i.minus) begin
          neg_d    = item_i.minus;
          adv      = 1'b1;
          consumed = 1'b1;
          phase_d  = PhSign;
        end else begin
          phase_d  = PhSign;
        end
      end
      if (!consumed) begin
        if (phase_d == PhSign) begin
          if ((base_d == BaseAuto || base_d == BaseHex) && item_i.zero) begin
            seen_d   = 1'b1;
            acc_d    = '0;
            adv      = 1'b1;
            zeo_d    = (pos_d >= MaxPos) ? pos_d : pos_d + 1'b1;
            phase_d  = PhZero;
            consumed = 1'b1;
          end else begin
            if (base_d == BaseAuto) begin
              base_d = BaseDec;
            end
            phase_d = PhDigits;
          end
        end else if (phase_d == PhZero) begin
          if (item_i.hex_x) begin
            adv      = 1'b1;
            phase_d  = PhZeroX;
            consumed = 1'b1;
          end else begin
            if (base_d == BaseAuto) begin
              base_d = (item_i.alnum && item_i.val < BaseOct) ? BaseOct : BaseDec;
            end
            phase_d = PhDigits;
          end
        end else if (phase_d == PhZeroX) begin
          consumed = 1'b1;
          if (!(item_i.alnum && item_i.val < BaseHex)) begin
            acc_d   = '0;
            fin     = 1'b1;
            conv    = 1'b1;
            fin_end = zeo_d;
          end else begin
            base_d  = BaseHex;
            acc_d   = {58'b0, item_i.val};
            adv     = 1'b1;
            phase_d = PhDigits;
          end
        end
      end
      if (!consumed && phase_d == PhDigits) begin
        dok = item_i.alnum && base_d >= BaseMin && base_d <= BaseMax
              && item_i.val < base_d;
        if (!dok) begin
          fin     = 1'b1;
          conv    = seen_d;
          fin_end = pos_d;
        end else begin
          acc_d  = acc_d * {58'b0, base_d} + {58'b0, item_i.val};
          seen_d = 1'b1;
          adv    = 1'b1;
        end
      end
      if (adv) begin
        if (pos_d >= MaxPos) begin
          sat_d = 1'b1;
        end else begin
          pos_d = pos_d + 1'b1;
        end
      end
      if (fin) begin
        phase_d = PhDone;
        v       = conv ? acc_d : '0;
        if (signed_mode_i) begin
          if (neg_d) begin
            r = v[63] ? SignedMin : (64'd0 - v);
          end else begin
            r = v[63] ? SignedMax : v;
          end
        end else begin
          r = neg_d ? (64'd0 - v) : v;
        end
        end_ext          = {13'b0, (conv ? fin_end : {PosW{1'b0}})};
        res_d.value_bits = r;
        res_d.end_offset = end_ext[12:0];
        res_d.converted  = conv;
        res_d.too_long   = sat_d;
        out_valid_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhDone;
      acc_q       <= '0;
      base_q      <= '0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      zeo_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      base_q      <= base_d;
      neg_q       <= neg_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      zeo_q       <= zeo_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

FILE: src/text_to_integer_parser.sv
// top level of the streaming text to integer parser with its register port
// depends on tip_pkg, tip_front, tip_fifo, tip_back
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   char_in_i, first_i
// out      out  out_valid_o / out_ready_i value_bits_o, end_offset_o, converted_o, too_long_o
// cfg      in   psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// one character per cycle while no result waits on the sink, set by the single 64x6 multiply-add on the accumulator
// a result is valid in the cycle after the parse engine pops the character that ends the parse from the queue
// a two-entry queue between classifier and parse engine absorbs output stalls
// reset returns the engine to done, waiting for a first character, base 0, signed on
`default_nettype none

module text_to_integer_parser import tip_pkg::*; #(
  parameter int MAX_LEN = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        first_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      value_bits_o,
  output logic [12:0]      end_offset_o,
  output logic             converted_o,
  output logic             too_long_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [5:0]  number_base_q;
  logic        signed_mode_q;
  logic        q_push, q_full, q_valid, q_pop;
  tip_item_t   q_in, q_out;
  tip_result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSignedMode) ? {31'b0, signed_mode_q}
                                              : {26'b0, number_base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= '0;
      signed_mode_q <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegNumberBase: number_base_q <= pwdata[5:0];
        RegSignedMode: signed_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  tip_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_in_i  (char_in_i),
    .first_i    (first_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  tip_fifo #(
    .WIDTH ($bits(tip_item_t)),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  tip_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_base_i (number_base_q),
    .signed_mode_i (signed_mode_q),
    .item_valid_i  (q_valid),
    .item_i        (q_out),
    .item_pop_o    (q_pop),
    .res_valid_o   (out_valid_o),
    .res_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign value_bits_o = res.value_bits;
  assign end_offset_o = res.end_offset;
  assign converted_o  = res.converted;
  assign too_long_o   = res.too_long;

endmodule

`default_nettype wire

FILE: src/tip_checker.sv
// port-level checks on the parser, attached to the top level by bind
// depends on text_to_integer_parser
`default_nettype none

module tip_checker #(
  parameter int MAX_LEN = 4096
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] value_bits_o,
  input wire logic [12:0] end_offset_o,
  input wire logic        converted_o,
  input wire logic        pready
);

  // a result waiting for the sink holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_bits_o))
    else $error("stalled result changed");

  // nothing converted means a zero value at offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converted_o |-> value_bits_o == 64'd0 && end_offset_o == 13'd0)
    else $error("unconverted result not zero");

  // offset never passes the length limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> end_offset_o <= MAX_LEN)
    else $error("end offset beyond length limit");

  // no result right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o && pready)
    else $error("result present after reset");

endmodule

bind text_to_integer_parser tip_checker #(.MAX_LEN(MAX_LEN)) u_tip_checker (.*);

`default_nettype wire
